### sv/psscan_pkg.sv
package psscan_pkg;

   // Sizes of the scanner
   localparam int ADDR_BITS = 32;
   localparam int LEN_LIMIT = 4096;
   localparam int LEN_W     = 13;
   localparam int THR_W     = 9;
   localparam int PROD_W    = LEN_W + THR_W;
   localparam int LEN_SAT   = LEN_LIMIT + 1;

   // Queue depths
   localparam int CAND_DEPTH = 2;
   localparam int CAND_PTR_W = $clog2(CAND_DEPTH);
   localparam int CAND_CNT_W = $clog2(CAND_DEPTH + 1);
   localparam int OUT_DEPTH  = 2;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

   // Control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_HIGH_BYTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_THRESHOLD  = 3'd4;
   localparam int CSR_DATA_W = 13;

   // Character classes
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [31:0]      string_start;
      logic [LEN_W-1:0] string_length;
   } rsp_type;

   typedef struct packed {
      logic             scan_enable;
      logic [LEN_W-1:0] min_length;
      logic [LEN_W-1:0] max_length;
      logic             allow_high_bytes;
      logic [THR_W-1:0] ratio_threshold;
   } cfg_type;

   // Closed run waiting to be judged
   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [LEN_W-1:0]     count;
      logic [LEN_W-1:0]     pcount;
   } cand_type;

endpackage

### sv/psscan_front.sv
module psscan_front
   import psscan_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  logic     cand_full,
   output logic     cand_push,
   output cand_type cand_data
);

   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic                 open_ff, open_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic [LEN_W-1:0]     pcount_ff, pcount_in;

   logic             fire;
   logic             is_print;
   logic             is_char;
   logic [LEN_W-1:0] cnt_base;
   logic [LEN_W-1:0] pcnt_base;
   logic [LEN_W-1:0] cnt_next;
   logic [LEN_W-1:0] pcnt_next;

   assign req_full = cand_full;
   assign fire     = req_push && !cand_full;

   // Byte classification
   assign is_print = (req_data.data_byte >= PRINT_LO) && (req_data.data_byte <= PRINT_HI);
   assign is_char  = (req_data.data_byte != 8'h00) &&
                     ((cfg.allow_high_bytes && req_data.data_byte[7]) || is_print);

   // Saturating run counters
   assign cnt_base  = open_ff ? count_ff : '0;
   assign pcnt_base = open_ff ? pcount_ff : '0;
   assign cnt_next  = (cnt_base < LEN_W'(LEN_SAT)) ? cnt_base + 1'b1 : cnt_base;
   assign pcnt_next = (is_print && pcnt_base < LEN_W'(LEN_SAT)) ? pcnt_base + 1'b1
                                                                : pcnt_base;

   // Run tracking and candidate hand-off
   always_comb begin
      pos_in    = pos_ff;
      open_in   = open_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      pcount_in = pcount_ff;
      cand_push = 1'b0;
      cand_data = '{start: start_ff, count: count_ff, pcount: pcount_ff};
      if (fire) begin
         pos_in = req_data.end_of_data ? '0 : pos_ff + 1'b1;
         if (is_char) begin
            start_in = open_ff ? start_ff : pos_ff;
            cand_data = '{start: start_in, count: cnt_next, pcount: pcnt_next};
            if (req_data.end_of_data) begin
               cand_push = cfg.scan_enable;
               open_in   = 1'b0;
               count_in  = '0;
               pcount_in = '0;
            end else begin
               open_in   = 1'b1;
               count_in  = cnt_next;
               pcount_in = pcnt_next;
            end
         end else begin
            cand_push = open_ff && cfg.scan_enable;
            open_in   = 1'b0;
            count_in  = '0;
            pcount_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         open_ff   <= 1'b0;
         count_ff  <= '0;
         pcount_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         open_ff   <= open_in;
         count_ff  <= count_in;
         pcount_ff <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

`ifndef SYNTHESIS
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(LEN_SAT))
      else $error("run count above saturation");
   a_pcount_le: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= count_ff)
      else $error("printable count exceeds run count");
   a_closed_zero: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (count_ff == '0 && pcount_ff == '0))
      else $error("closed run holds counts");
   a_push_len: assert property (@(posedge clock) disable iff (reset)
      cand_push |-> cand_data.count != '0)
      else $error("empty run handed to judge");
`endif

endmodule

### sv/psscan_cand_queue.sv
module psscan_cand_queue
   import psscan_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cand_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output cand_type head
);

   cand_type              mem_ff [CAND_DEPTH];
   logic [CAND_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CAND_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CAND_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (cnt_ff == CAND_CNT_W'(CAND_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CAND_PTR_W'(CAND_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CAND_PTR_W'(CAND_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAND_CNT_W'(CAND_DEPTH))
      else $error("candidate queue overfilled");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("candidate pushed into full queue");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CAND_CNT_W'(1) && do_pop && !do_push) |=> empty)
      else $error("candidate queue not empty after last pop");
`endif

endmodule

### sv/psscan_back.sv
module psscan_back
   import psscan_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     cand_empty,
   input  cand_type cand_head,
   output logic     cand_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   rsp_type              mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] cnt_ff, cnt_in;

   logic              out_full;
   logic              do_pop;
   logic              do_push;
   logic              pass;
   logic [LEN_W-1:0]  hi_len;
   logic [PROD_W-1:0] lhs;
   logic [PROD_W-1:0] rhs;

   // Run judge: length window and printable ratio
   assign hi_len = (cfg.max_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : cfg.max_length;
   assign lhs    = PROD_W'({cand_head.pcount, 8'h00});
   assign rhs    = PROD_W'(cfg.ratio_threshold) * PROD_W'(cand_head.count);
   assign pass   = (cand_head.count != '0) && (cand_head.count >= cfg.min_length) &&
                   (cand_head.count <= hi_len) && (lhs >= rhs);

   // Result queue handshake
   assign out_full  = (cnt_ff == OUT_CNT_W'(OUT_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign cand_pop  = !cand_empty && (!out_full || do_pop);
   assign do_push   = cand_pop && pass;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= '{string_start: 32'(cand_head.start),
                                string_length: cand_head.count};
      end
   end

`ifndef SYNTHESIS
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue overfilled");
   a_push_window: assert property (@(posedge clock) disable iff (reset)
      do_push |-> (cand_head.count >= cfg.min_length && cand_head.count <= hi_len))
      else $error("run outside length window reported");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      do_push |-> (!out_full || do_pop))
      else $error("result pushed into full queue");
`endif

endmodule

### sv/printable_run_string_scanner.sv
// Printable-string scanner: one image byte enters per cycle through req_push while req_full is low, and each
// run of string characters that passes the length window and printable-ratio test comes out
// as one request on the rsp_ side (start offset, length). A closed run enters the two-entry
// candidate queue at the edge that accepts its closing byte and is judged into the two-entry
// result queue once that queue has room, so it can be popped after it is written there.
// Input is taken whenever req_full is low; req_full rises only when the candidate queue is
// full, which happens when the result side is not popped. No clearing pass after reset.
// csr_ready is always high; write registers only while the scanner is idle.
module printable_run_string_scanner
   import psscan_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     cand_push;
   cand_type cand_data;
   logic     cand_full;
   logic     cand_empty;
   logic     cand_pop;
   cand_type cand_head;

   assign csr_ready = 1'b1;

   // Control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SCAN_ENABLE:      cfg_in.scan_enable      = csr_data[0];
            CSR_MIN_LENGTH:       cfg_in.min_length       = csr_data[LEN_W-1:0];
            CSR_MAX_LENGTH:       cfg_in.max_length       = csr_data[LEN_W-1:0];
            CSR_ALLOW_HIGH_BYTES: cfg_in.allow_high_bytes = csr_data[0];
            CSR_RATIO_THRESHOLD:  cfg_in.ratio_threshold  = csr_data[THR_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{scan_enable: 1'b1,
                     min_length: LEN_W'(4),
                     max_length: LEN_W'(LEN_LIMIT),
                     allow_high_bytes: 1'b1,
                     ratio_threshold: THR_W'(180)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psscan_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cand_full (cand_full),
      .cand_push (cand_push),
      .cand_data (cand_data)
   );

   psscan_cand_queue u_cand_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_push),
      .push_data (cand_data),
      .full      (cand_full),
      .pop       (cand_pop),
      .empty     (cand_empty),
      .head      (cand_head)
   );

   psscan_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cand_empty (cand_empty),
      .cand_head  (cand_head),
      .cand_pop   (cand_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
